// ----- hw/rtl/pixel_blend_unit_macros.svh -----
// pixel_blend_unit_macros.svh: assertion macros for the pixel blend unit
// expects aclk and aresetn in the scope where a macro is used
`ifndef PIXEL_BLEND_UNIT_MACROS_SVH
`define PIXEL_BLEND_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PBU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pixel_blend_unit assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PBU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pixel_blend_unit assertion failed");

`endif

// ----- hw/rtl/pbu_pkg.sv -----
// pbu_pkg: shared types and constants of the pixel blend unit
// no dependencies
`timescale 1ns / 1ps

package pbu_pkg;

    localparam int PIXEL_W = 32;
    localparam int MODE_W  = 4;
    localparam int ALPHA_W = 8;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;

    // blend mode codes
    localparam logic [MODE_W-1:0] MODE_COPY      = 4'd0;
    localparam logic [MODE_W-1:0] MODE_KEY       = 4'd1;
    localparam logic [MODE_W-1:0] MODE_COLORIZE  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_ALPHA     = 4'd3;
    localparam logic [MODE_W-1:0] MODE_KEY_ALPHA = 4'd4;
    localparam logic [MODE_W-1:0] MODE_HALF      = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ADD       = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SUB       = 4'd7;
    localparam logic [MODE_W-1:0] MODE_ALPHA_ADD = 4'd8;
    localparam logic [MODE_W-1:0] MODE_MUL       = 4'd9;
    localparam logic [MODE_W-1:0] MODE_INVERT    = 4'd10;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_BLEND_MODE  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_ALPHA_LEVEL = 2'd1;
    localparam logic [CIDX_W-1:0] REG_FILL_COLOR  = 2'd2;

    // color key: a source whose rgb bytes are all zero is transparent
    localparam logic [23:0] KEY_MASK = 24'hffffff;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ALPHA_W-1:0] alpha;
        logic [PIXEL_W-1:0] fill;
    } cfg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               written;
    } result_t;

endpackage

// ----- hw/rtl/pbu_lane.sv -----
// pbu_lane: one byte lane of the blend datapath, all modes
// depends on pbu_pkg
`timescale 1ns / 1ps

module pbu_lane (
    input  logic [pbu_pkg::MODE_W-1:0]  mode,
    input  logic [pbu_pkg::ALPHA_W-1:0] alpha,
    input  logic [7:0]                  fill_b,
    input  logic [7:0]                  src_b,
    input  logic [7:0]                  dst_b,
    input  logic                        is_alpha_lane,
    output logic [7:0]                  res_b
);

    // 12-bit widening, (b*257)>>4
    logic [11:0] s12, d12, a12;
    assign s12 = {src_b, src_b[7:4]};
    assign d12 = {dst_b, dst_b[7:4]};
    assign a12 = {alpha, alpha[7:4]};

    // alpha blend: s + floor((d12-s12)*a12 / 2^16), clamped
    logic signed [12:0] diff;
    logic signed [25:0] prod_a;
    logic signed [9:0]  blend_sum;
    logic [7:0]         blend_b;
    assign diff      = $signed({1'b0, d12}) - $signed({1'b0, s12});
    assign prod_a    = diff * $signed({1'b0, a12});
    assign blend_sum = $signed({2'b00, src_b}) + prod_a[25:16];
    always_comb begin
        if (blend_sum < 0) begin
            blend_b = 8'd0;
        end else if (blend_sum > 10'sd255) begin
            blend_b = 8'hff;
        end else begin
            blend_b = blend_sum[7:0];
        end
    end

    // multiply, top byte of the 24-bit product never exceeds 255
    logic [23:0] prod_m;
    assign prod_m = s12 * d12;

    logic [7:0] half_b;
    assign half_b = {1'b0, src_b[7:1]} + {1'b0, dst_b[7:1]};

    logic [8:0] add_sum;
    logic [7:0] add_b;
    assign add_sum = {1'b0, src_b} + {1'b0, dst_b};
    assign add_b   = add_sum[8] ? 8'hff : add_sum[7:0];

    logic [7:0] sub_b;
    assign sub_b = (dst_b > src_b) ? (dst_b - src_b) : 8'd0;

    // scaled add, alpha lane contributes nothing
    logic [15:0] prod_s;
    logic [7:0]  scaled_b;
    logic [8:0]  sadd_sum;
    logic [7:0]  sadd_b;
    assign prod_s   = src_b * alpha;
    assign scaled_b = is_alpha_lane ? 8'd0 : prod_s[15:8];
    assign sadd_sum = {1'b0, scaled_b} + {1'b0, dst_b};
    assign sadd_b   = sadd_sum[8] ? 8'hff : sadd_sum[7:0];

    // inverse difference, alpha lane forced to zero
    logic [7:0]  inv_s;
    logic [7:0]  inv_d;
    logic [15:0] inv_p0, inv_p1;
    logic [16:0] inv_sum;
    logic [7:0]  inv_b;
    assign inv_s   = ~src_b;
    assign inv_d   = ~dst_b;
    assign inv_p0  = inv_s * dst_b;
    assign inv_p1  = src_b * inv_d;
    assign inv_sum = {1'b0, inv_p0} + {1'b0, inv_p1};
    assign inv_b   = is_alpha_lane ? 8'd0 : inv_sum[15:8];

    always_comb begin
        unique case (mode)
            pbu_pkg::MODE_COPY,
            pbu_pkg::MODE_KEY:       res_b = src_b;
            pbu_pkg::MODE_COLORIZE:  res_b = fill_b;
            pbu_pkg::MODE_ALPHA,
            pbu_pkg::MODE_KEY_ALPHA: res_b = blend_b;
            pbu_pkg::MODE_HALF:      res_b = half_b;
            pbu_pkg::MODE_ADD:       res_b = add_b;
            pbu_pkg::MODE_SUB:       res_b = sub_b;
            pbu_pkg::MODE_ALPHA_ADD: res_b = sadd_b;
            pbu_pkg::MODE_MUL:       res_b = prod_m[23:16];
            pbu_pkg::MODE_INVERT:    res_b = inv_b;
            default:                 res_b = dst_b;
        endcase
    end

endmodule

// ----- hw/rtl/pbu_datapath.sv -----
// pbu_datapath: four byte lanes plus color key and skip decision
// depends on pbu_pkg and pbu_lane
`timescale 1ns / 1ps

module pbu_datapath (
    input  pbu_pkg::cfg_t                cfg,
    input  logic [pbu_pkg::PIXEL_W-1:0]  src,
    input  logic [pbu_pkg::PIXEL_W-1:0]  dst,
    output pbu_pkg::result_t             res
);

    logic [pbu_pkg::PIXEL_W-1:0] lane_pixel;
    logic                        key_hit;
    logic                        write_en;

    for (genvar k = 0; k < 4; k++) begin : g_lane
        pbu_lane u_lane (
            .mode          (cfg.mode),
            .alpha         (cfg.alpha),
            .fill_b        (cfg.fill[8*k +: 8]),
            .src_b         (src[8*k +: 8]),
            .dst_b         (dst[8*k +: 8]),
            .is_alpha_lane (k == 3),
            .res_b         (lane_pixel[8*k +: 8])
        );
    end

    assign key_hit = (src[23:0] & pbu_pkg::KEY_MASK) == 24'd0;

    always_comb begin
        unique case (cfg.mode)
            pbu_pkg::MODE_KEY,
            pbu_pkg::MODE_COLORIZE,
            pbu_pkg::MODE_KEY_ALPHA: write_en = !key_hit;
            pbu_pkg::MODE_COPY,
            pbu_pkg::MODE_ALPHA,
            pbu_pkg::MODE_HALF,
            pbu_pkg::MODE_ADD,
            pbu_pkg::MODE_SUB,
            pbu_pkg::MODE_ALPHA_ADD,
            pbu_pkg::MODE_MUL,
            pbu_pkg::MODE_INVERT:    write_en = 1'b1;
            default:                 write_en = 1'b0;
        endcase
    end

    // skipped pixels keep the destination
    assign res.pixel   = write_en ? lane_pixel : dst;
    assign res.written = write_en;

endmodule

// ----- hw/rtl/pixel_blend_unit.sv -----
// pixel_blend_unit: top level, config registers, input and result registers
// depends on pbu_pkg, pbu_datapath, pbu_lane and pixel_blend_unit_macros.svh
`timescale 1ns / 1ps
//
// usage
//   s_ channel: one beat carries a source and a destination argb pixel
//   m_ channel: one beat carries the blended pixel and a written flag;
//               written low means the pixel was skipped (color key or
//               unused mode) and the pixel field holds the destination
//   cfg port:   cfg_wr_en with cfg_index 0 blend_mode, 1 alpha_level,
//               2 fill_color; write only while no beat is in flight
// timing
//   an accepted beat is held in the input register, then in the result register,
//   from which it leaves on m_; one beat per cycle sustained while m_tready
//   stays high; all blend math for a pixel is one pass of per-lane logic
//   between the two registers
// reset
//   aresetn low (synchronous) empties both registers and clears all
//   configuration registers to zero (copy mode)
// stall
//   while m_tready is low the result holds; the input register still
//   takes one more beat, then s_tready drops until the result drains
//
`include "pixel_blend_unit_macros.svh"

module pixel_blend_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic [pbu_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [pbu_pkg::CFG_W-1:0]    cfg_data,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [63:0]                  s_tdata,   // [31:0] src_pixel, [63:32] dst_pixel
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // [31:0] out_pixel
    output logic [0:0]                   m_tuser    // [0] written
);

    // configuration registers
    logic [pbu_pkg::MODE_W-1:0]  mode_reg;
    logic [pbu_pkg::ALPHA_W-1:0] alpha_reg;
    logic [pbu_pkg::PIXEL_W-1:0] fill_reg;
    pbu_pkg::cfg_t               cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= '0;
            alpha_reg <= '0;
            fill_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pbu_pkg::REG_BLEND_MODE:  mode_reg  <= cfg_data[pbu_pkg::MODE_W-1:0];
                pbu_pkg::REG_ALPHA_LEVEL: alpha_reg <= cfg_data[pbu_pkg::ALPHA_W-1:0];
                pbu_pkg::REG_FILL_COLOR:  fill_reg  <= cfg_data[pbu_pkg::PIXEL_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    assign cfg.mode  = mode_reg;
    assign cfg.alpha = alpha_reg;
    assign cfg.fill  = fill_reg;

    // pipeline control
    logic in_valid_reg,  in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_load;
    logic in_load;

    // result register takes a beat when empty or being drained
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    assign in_valid_next  = in_load || (in_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register, payload only
    logic [pbu_pkg::PIXEL_W-1:0] src_reg, dst_reg;

    always_ff @(posedge aclk) begin
        if (in_load) begin
            src_reg <= s_tdata[31:0];
            dst_reg <= s_tdata[63:32];
        end
    end

    // blend logic
    pbu_pkg::result_t res;

    pbu_datapath u_datapath (
        .cfg (cfg),
        .src (src_reg),
        .dst (dst_reg),
        .res (res)
    );

    // result register
    logic [pbu_pkg::PIXEL_W-1:0] out_pixel_reg;
    logic                        out_written_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_pixel_reg   <= res.pixel;
            out_written_reg <= res.written;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_pixel_reg;
    assign m_tuser[0] = out_written_reg;

    // checks
    `PBU_ASSERT_NEXT(a_accept_fills_input, s_tvalid && s_tready, in_valid_reg)
    `PBU_ASSERT_NEXT(a_move_fills_result, out_load, m_tvalid)
    `PBU_ASSERT_SAME(a_full_blocks_input, in_valid_reg && m_tvalid && !m_tready, !s_tready)
    `PBU_ASSERT_SAME(a_skip_keeps_dst, in_valid_reg && !res.written, res.pixel == dst_reg)

endmodule

// ----- test/pixel_blend_unit_tb.sv -----
// pixel_blend_unit_tb: self-checking testbench for the argb8888 pixel blend unit
// depends on pbu_pkg and pixel_blend_unit; drives pixel pairs, predicts each blended beat
`timescale 1ns / 1ps

module pixel_blend_unit_tb;

    localparam logic [31:0] HALF_MASK = 32'h7f7f7f7f;
    localparam int RANDOM_ITEMS = 1000;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [pbu_pkg::CIDX_W-1:0]   cfg_index = '0;
    logic [pbu_pkg::CFG_W-1:0]    cfg_data  = '0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [63:0]                  s_tdata   = '0;   // [31:0] src_pixel, [63:32] dst_pixel
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [31:0]                  m_tdata;          // [31:0] out_pixel
    logic [0:0]                   m_tuser;          // [0] written

    // shadow of the configuration registers, as last written
    logic [pbu_pkg::MODE_W-1:0]   mode_reg  = pbu_pkg::MODE_COPY;
    logic [pbu_pkg::ALPHA_W-1:0]  alpha_reg = '0;
    logic [pbu_pkg::PIXEL_W-1:0]  fill_reg  = '0;

    // blended pixels still owed by the block, oldest first
    pbu_pkg::result_t pending_pixels[$];
    int               mismatch_count = 0;

    // sender burst state
    int burst_left = 0;

    // receiver stall state
    int         stall_style = 0;
    int         style_left  = 0;
    logic [7:0] stall_pattern = 8'hff;

    pixel_blend_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------
    // blend predictor
    // ---------------------------------------------------------------

    // byte widened to 12 bits, (b*257)>>4
    function automatic int widen12(input logic [7:0] b);
        return (int'(b) * 257) >>> 4;
    endfunction

    // high half of a signed product, rounded toward minus infinity
    function automatic int mul_hi(input int a, input int b);
        return (a * b) >>> 16;
    endfunction

    function automatic logic [7:0] sat8(input int v);
        if (v < 0) return 8'h00;
        if (v > 255) return 8'hff;
        return v[7:0];
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        logic [8:0]  sum;
        for (int k = 0; k < 4; k++) begin
            sum = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
            r[8*k +: 8] = sum[8] ? 8'hff : sum[7:0];
        end
        return r;
    endfunction

    // constant-alpha mix of each lane toward the destination
    function automatic logic [31:0] alpha_mix(input logic [31:0] src, input logic [31:0] dst);
        logic [31:0] r;
        int          a12;
        int          diff;
        a12 = widen12(alpha_reg);
        for (int k = 0; k < 4; k++) begin
            diff = widen12(dst[8*k +: 8]) - widen12(src[8*k +: 8]);
            r[8*k +: 8] = sat8(int'(src[8*k +: 8]) + mul_hi(diff, a12));
        end
        return r;
    endfunction

    function automatic pbu_pkg::result_t blend_pixel(input logic [31:0] src,
                                                     input logic [31:0] dst);
        pbu_pkg::result_t res;
        logic        keyed;
        logic [31:0] scaled_rb;
        logic [31:0] scaled_g;
        int          inv;
        int          t;
        int          v;
        keyed = (src[23:0] & pbu_pkg::KEY_MASK) == 24'h0;
        res.pixel = dst;
        res.written = 1'b1;
        case (mode_reg)
            pbu_pkg::MODE_COPY: res.pixel = src;
            pbu_pkg::MODE_KEY: begin
                if (keyed) res.written = 1'b0;
                else res.pixel = src;
            end
            pbu_pkg::MODE_COLORIZE: begin
                if (keyed) res.written = 1'b0;
                else res.pixel = fill_reg;
            end
            pbu_pkg::MODE_ALPHA: res.pixel = alpha_mix(src, dst);
            pbu_pkg::MODE_KEY_ALPHA: begin
                if (keyed) res.written = 1'b0;
                else res.pixel = alpha_mix(src, dst);
            end
            pbu_pkg::MODE_HALF: res.pixel = ((src >> 1) & HALF_MASK) + ((dst >> 1) & HALF_MASK);
            pbu_pkg::MODE_ADD: res.pixel = add_sat(src, dst);
            pbu_pkg::MODE_SUB: begin
                for (int k = 0; k < 4; k++)
                    res.pixel[8*k +: 8] = (dst[8*k +: 8] > src[8*k +: 8]) ?
                                          dst[8*k +: 8] - src[8*k +: 8] : 8'h00;
            end
            pbu_pkg::MODE_ALPHA_ADD: begin
                // red/blue scaled together, green alone, alpha lane dropped
                scaled_rb = (((src & 32'h00ff00ff) * {24'h0, alpha_reg}) >> 8) & 32'h00ff00ff;
                scaled_g  = (((src & 32'h0000ff00) * {24'h0, alpha_reg}) >> 8) & 32'h0000ff00;
                res.pixel = add_sat(scaled_rb + scaled_g, dst);
            end
            pbu_pkg::MODE_MUL: begin
                for (int k = 0; k < 4; k++)
                    res.pixel[8*k +: 8] = sat8(mul_hi(widen12(src[8*k +: 8]),
                                                      widen12(dst[8*k +: 8])));
            end
            pbu_pkg::MODE_INVERT: begin
                res.pixel = '0;
                for (int k = 0; k < 3; k++) begin
                    inv = 255 - int'(src[8*k +: 8]);
                    t   = int'(dst[8*k +: 8]);
                    v   = (inv * t + (255 - inv) * (255 - t)) >>> 8;
                    res.pixel[8*k +: 8] = v[7:0];
                end
            end
            // unused modes leave the destination alone
            default: res.written = 1'b0;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    always @(posedge aclk) begin : check_result
        pbu_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: result beat with none expected, got pixel %h written %b",
                         $time, m_tdata, m_tuser[0]);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata !== want.pixel) begin
                    $display("%0t: out_pixel expected %h got %h", $time, want.pixel, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.written) begin
                    $display("%0t: written expected %b got %b", $time, want.written,
                             m_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver back-pressure: a style is held for a while, then swapped
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (style_left == 0) begin
            stall_style   <= $urandom_range(0, 3);
            style_left    <= $urandom_range(32, 200);
            stall_pattern <= 8'($urandom) | 8'h01;   // at least one ready slot per turn
            m_tready      <= 1'b1;
        end else begin
            style_left <= style_left - 1;
            case (stall_style)
                0: m_tready <= 1'b1;                           // never stall
                1: m_tready <= ($urandom_range(0, 3) != 0);     // light stalls
                2: m_tready <= ($urandom_range(0, 3) == 0);     // heavy stalls
                default: begin                                  // rotating pattern
                    m_tready      <= stall_pattern[0];
                    stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // one pixel pair per beat, sent in bursts with random gaps between
    task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {dst, src};
        do @(posedge aclk); while (!s_tready);
        pending_pixels.push_back(blend_pixel(src, dst));
    endtask

    // drop valid and wait until every owed beat has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    // registers change only with nothing in flight; spare upper bits carry junk
    task automatic configure(input logic [pbu_pkg::MODE_W-1:0] mode,
                             input logic [pbu_pkg::ALPHA_W-1:0] alpha,
                             input logic [pbu_pkg::PIXEL_W-1:0] fill);
        logic [31:0] junk;
        wait_drained();
        junk = $urandom;
        cfg_wr_en <= 1'b1;
        cfg_index <= pbu_pkg::REG_BLEND_MODE;
        cfg_data  <= {junk[31:pbu_pkg::MODE_W], mode};
        @(posedge aclk);
        mode_reg = mode;
        cfg_index <= pbu_pkg::REG_ALPHA_LEVEL;
        cfg_data  <= {junk[31-pbu_pkg::ALPHA_W:0], alpha};
        @(posedge aclk);
        alpha_reg = alpha;
        cfg_index <= pbu_pkg::REG_FILL_COLOR;
        cfg_data  <= fill;
        @(posedge aclk);
        fill_reg = fill;
        cfg_wr_en <= 1'b0;
    endtask

    // bytes lean toward 0x00 and 0xff so saturation and zero lanes show up
    function automatic logic [31:0] rand_pixel();
        logic [31:0] p;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 3))
                0: p[8*k +: 8] = 8'h00;
                1: p[8*k +: 8] = 8'hff;
                default: p[8*k +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_copy_and_key();
        configure(pbu_pkg::MODE_COPY, 8'h00, 32'h0);
        send_pixel(32'hffffffff, 32'h00000000);
        // opaque-black alpha with zero rgb is still the key color
        configure(pbu_pkg::MODE_KEY, 8'hff, 32'h0);
        send_pixel(32'hff000000, 32'hdeadbeef);
        send_pixel(32'h00000001, 32'h12345678);
        configure(pbu_pkg::MODE_COLORIZE, 8'h00, 32'hffffffff);
        send_pixel(32'h00000000, 32'ha5a5a5a5);
        send_pixel(32'h00800000, 32'h00000000);
    endtask

    task automatic test_alpha_blend();
        // full weight pulls toward dst, zero weight keeps src
        configure(pbu_pkg::MODE_ALPHA, 8'hff, 32'h0);
        send_pixel(32'hffffffff, 32'h00000000);
        send_pixel(32'h00000000, 32'hffffffff);
        configure(pbu_pkg::MODE_ALPHA, 8'h00, 32'h0);
        send_pixel(32'h12345678, 32'h9abcdef0);
        configure(pbu_pkg::MODE_KEY_ALPHA, 8'h80, 32'h0);
        send_pixel(32'h7f000000, 32'hffffffff);
        send_pixel(32'h00010000, 32'hff00ff00);
    endtask

    task automatic test_lane_ops();
        configure(pbu_pkg::MODE_HALF, 8'h00, 32'h0);
        send_pixel(32'hffffffff, 32'hffffffff);
        configure(pbu_pkg::MODE_ADD, 8'h00, 32'h0);
        send_pixel(32'hffffffff, 32'h01010101);
        configure(pbu_pkg::MODE_SUB, 8'h00, 32'h0);
        send_pixel(32'hffffffff, 32'h00000000);
        configure(pbu_pkg::MODE_MUL, 8'h00, 32'h0);
        send_pixel(32'hffffffff, 32'hffffffff);
        configure(pbu_pkg::MODE_INVERT, 8'h00, 32'h0);
        send_pixel(32'h00ff00ff, 32'h0f0f0ff0);
    endtask

    task automatic test_alpha_add();
        // zero alpha passes dst through but still counts as written
        configure(pbu_pkg::MODE_ALPHA_ADD, 8'h00, 32'h0);
        send_pixel(32'hffffffff, 32'h12345678);
        configure(pbu_pkg::MODE_ALPHA_ADD, 8'hff, 32'h0);
        send_pixel(32'hffffffff, 32'h80808080);
    endtask

    task automatic test_unused_modes();
        for (int m = int'(pbu_pkg::MODE_INVERT) + 1; m < (1 << pbu_pkg::MODE_W); m++) begin
            configure(m[pbu_pkg::MODE_W-1:0], 8'hff, 32'hffffffff);
            send_pixel(32'hffffffff, 32'h5a5a5a5a);
        end
    endtask

    // random phases: fresh settings each phase, then a run of pixel pairs
    task automatic test_random_traffic();
        int                          sent;
        int                          phase_len;
        logic [pbu_pkg::MODE_W-1:0]  mode;
        logic [pbu_pkg::ALPHA_W-1:0] alpha;
        logic [31:0]                 src;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                mode = pbu_pkg::MODE_W'($urandom_range(int'(pbu_pkg::MODE_INVERT) + 1,
                                                       (1 << pbu_pkg::MODE_W) - 1));
            else
                mode = pbu_pkg::MODE_W'($urandom_range(int'(pbu_pkg::MODE_COPY),
                                                       int'(pbu_pkg::MODE_INVERT)));
            case ($urandom_range(0, 3))
                0: alpha = 8'h00;
                1: alpha = 8'hff;
                default: alpha = 8'($urandom_range(0, 255));
            endcase
            configure(mode, alpha, rand_pixel());
            phase_len = $urandom_range(20, 100);
            for (int n = 0; n < phase_len; n++) begin
                // some sources carry the key color with a random alpha byte
                if ($urandom_range(0, 5) == 0)
                    src = {8'($urandom_range(0, 255)), 24'h0};
                else
                    src = rand_pixel();
                send_pixel(src, rand_pixel());
            end
            sent += phase_len;
        end
    endtask

    // ---------------------------------------------------------------
    // run
    // ---------------------------------------------------------------

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_copy_and_key();
        test_alpha_blend();
        test_lane_ops();
        test_alpha_add();
        test_unused_modes();
        test_random_traffic();
        wait_drained();
        // keep the clock running to catch stray result beats
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("pixel_blend_unit test passed");
        else
            $display("pixel_blend_unit test failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("pixel_blend_unit test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pbu_pkg.sv
hw/rtl/pbu_lane.sv
hw/rtl/pbu_datapath.sv
hw/rtl/pixel_blend_unit.sv
test/pixel_blend_unit_tb.sv
